FILE: hdl/pure_pursuit_path_follower_top_assert.svh
// Assertion macros for the path follower top level.
`ifndef PURE_PURSUIT_PATH_FOLLOWER_TOP_ASSERT_SVH
`define PURE_PURSUIT_PATH_FOLLOWER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path follower check failed");

// Next-cycle implication.
`define PPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path follower check failed");

`endif

FILE: hdl/ppf_pkg.sv
package ppf_pkg;

  localparam int PATH_DEPTH = 256;
  localparam int IDX_W      = $clog2(PATH_DEPTH);
  localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

  localparam int POS_W   = 24;
  localparam int HEAD_W  = 15;
  localparam int DIFF_W  = POS_W + 1;
  localparam int DIST_W  = 2 * DIFF_W;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TICK_W  = 8;
  localparam int SPEED_W = 16;
  localparam int RATE_W  = 14;
  localparam int ANG_W   = 18;

  localparam int CORDIC_SHIFT = 16;
  localparam int CX_W         = DIFF_W + CORDIC_SHIFT + 3;
  localparam int CORDIC_STEPS = 13;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int PIPE_LAT = 3;
  localparam int WAIT_W   = 2;

  localparam logic signed [ANG_W-1:0] ANG_PI     = ANG_W'(12868);
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = ANG_W'(25736);
  localparam logic signed [ANG_W-1:0] ROT_TOL    = ANG_W'(410);
  localparam logic signed [RATE_W-1:0] ROT_RATE  = RATE_W'(4506);

  // Gain of 1.2 as (|err| * 6 + 2) / 5, the division done by reciprocal.
  localparam int VAL_W       = 18;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(104858);
  localparam int MAG_W       = VAL_W + RECIP_W - RECIP_SHIFT;
  localparam logic [MAG_W-1:0] MAX_RATE = MAG_W'(6144);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_TOL,
    CFG_CRUISE,
    CFG_LOOKAHEAD,
    CFG_STARTUP
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SCAN_GOAL,
    SCAN_MIN,
    SCAN_LA
  } scan_mode_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_GOAL,
    OUT_FOLLOW
  } out_kind_t;

  typedef struct packed {
    logic             mem_we;
    logic             mem_rd;
    logic [IDX_W-1:0] addr;
    logic             pose_load;
    logic             copy_end;
    scan_mode_t       scan_mode;
    logic             scan_clear;
    logic             cordic_start;
    logic             cordic_step;
    logic [STEP_W-1:0] step;
    logic             rate_calc;
    logic             out_load;
    out_kind_t        out_kind;
    logic             out_rev;
  } ppf_cmd_t;

  typedef struct packed {
    logic             goal_hit;
    logic [IDX_W-1:0] closest;
    logic             out_busy;
  } ppf_stat_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      4'd0:    r = ANG_W'(3217);
      4'd1:    r = ANG_W'(1899);
      4'd2:    r = ANG_W'(1003);
      4'd3:    r = ANG_W'(509);
      4'd4:    r = ANG_W'(256);
      4'd5:    r = ANG_W'(128);
      4'd6:    r = ANG_W'(64);
      4'd7:    r = ANG_W'(32);
      4'd8:    r = ANG_W'(16);
      4'd9:    r = ANG_W'(8);
      4'd10:   r = ANG_W'(4);
      4'd11:   r = ANG_W'(2);
      4'd12:   r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Inputs stay within two turns of the range, so two corrections suffice.
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    r = a;
    for (int k = 0; k < 2; k++) begin
      if (r > ANG_PI) begin
        r = r - ANG_TWO_PI;
      end else if (r < -ANG_PI) begin
        r = r + ANG_TWO_PI;
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/pure_pursuit_path_follower_top.sv
// Path load beats are taken in the idle state, and so is a tick in the startup window.
// A tick with no path loads a zero output, one at the goal a rotate command, and one when
// following makes two passes over the path memory at one point a cycle, then 13 CORDIC
// iterations. One beat is worked on at a time, and a tick waits in its output state while
// the previous result is still held.
// Reset is synchronous and active high; it restores the registers to their defaults and
// empties the path, but the path memory itself is not cleared.
`include "pure_pursuit_path_follower_top_assert.svh"

module pure_pursuit_path_follower_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // pos_x, pos_y, heading, zero pad
  input  logic [0:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // linear_speed, angular_rate, reverse_signal, rotating
  input  logic        cfg_we,
  input  logic [ppf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ppf_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [ppf_pkg::CFG_W-1:0]  goal_tolerance, cruise_speed, look_ahead;
  logic [ppf_pkg::TICK_W-1:0] startup_ticks;

  ppf_pkg::ppf_cmd_t  cmd;
  ppf_pkg::ppf_stat_t stat;

  logic [ppf_pkg::SPEED_W-1:0]       linear_speed;
  logic signed [ppf_pkg::RATE_W-1:0] angular_rate;
  logic                              reverse_signal, rotating;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_tolerance <= ppf_pkg::CFG_W'(512);
      cruise_speed   <= ppf_pkg::CFG_W'(512);
      look_ahead     <= ppf_pkg::CFG_W'(1024);
      startup_ticks  <= ppf_pkg::TICK_W'(20);
    end else if (cfg_we) begin
      unique case (ppf_pkg::cfg_idx_t'(cfg_addr))
        ppf_pkg::CFG_GOAL_TOL:  goal_tolerance <= cfg_wdata;
        ppf_pkg::CFG_CRUISE:    cruise_speed   <= cfg_wdata;
        ppf_pkg::CFG_LOOKAHEAD: look_ahead     <= cfg_wdata;
        ppf_pkg::CFG_STARTUP:   startup_ticks  <= cfg_wdata[ppf_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  ppf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_mode       (s_axis_tuser[0]),
    .in_last       (s_axis_tlast),
    .startup_ticks (startup_ticks),
    .cmd           (cmd),
    .stat          (stat)
  );

  ppf_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_x               (signed'(s_axis_tdata[23:0])),
    .in_y               (signed'(s_axis_tdata[47:24])),
    .in_heading         (signed'(s_axis_tdata[62:48])),
    .goal_tolerance     (goal_tolerance),
    .cruise_speed       (cruise_speed),
    .look_ahead         (look_ahead),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .linear_speed       (linear_speed),
    .angular_rate       (angular_rate),
    .reverse_signal     (reverse_signal),
    .rotating           (rotating)
  );

  assign m_axis_tdata = {rotating, reverse_signal, angular_rate, linear_speed};

  `PPF_ASSERT_IMP(a_rate_bound, m_axis_tvalid, (angular_rate <= 14'sd6144) && (angular_rate >= -14'sd6144))
  `PPF_ASSERT_IMP(a_rot_stopped, m_axis_tvalid && rotating, linear_speed == '0)
  `PPF_ASSERT_NXT(a_load_one_beat, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], s_axis_tready)
  `PPF_ASSERT_IMP(a_rev_in_goal, m_axis_tvalid && reverse_signal, rotating)

endmodule

FILE: hdl/ppf_datapath.sv
module ppf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ppf_pkg::ppf_cmd_t                   cmd,
  output ppf_pkg::ppf_stat_t                  stat,
  input  logic signed [ppf_pkg::POS_W-1:0]    in_x,
  input  logic signed [ppf_pkg::POS_W-1:0]    in_y,
  input  logic signed [ppf_pkg::HEAD_W-1:0]   in_heading,
  input  logic [ppf_pkg::CFG_W-1:0]           goal_tolerance,
  input  logic [ppf_pkg::CFG_W-1:0]           cruise_speed,
  input  logic [ppf_pkg::CFG_W-1:0]           look_ahead,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ppf_pkg::SPEED_W-1:0]         linear_speed,
  output logic signed [ppf_pkg::RATE_W-1:0]   angular_rate,
  output logic                                reverse_signal,
  output logic                                rotating
);

  logic [2*ppf_pkg::POS_W-1:0] path_mem [ppf_pkg::PATH_DEPTH];
  logic [2*ppf_pkg::POS_W-1:0] rd_data;

  logic signed [ppf_pkg::POS_W-1:0] px, py;
  logic signed [ppf_pkg::ANG_W-1:0] latest_heading, end_heading;

  logic                      v1, v2;
  ppf_pkg::scan_mode_t       m1, m2;
  logic [ppf_pkg::IDX_W-1:0] i1, i2;

  logic signed [ppf_pkg::DIFF_W-1:0] dx, dy, dx2, dy2, tdx, tdy;
  logic signed [ppf_pkg::DIST_W-1:0] sqx_c, sqy_c;
  logic [ppf_pkg::DIST_W-1:0]        sqx, sqy, dsq;
  logic [2*ppf_pkg::CFG_W-1:0]       tol_sq, la_sq;

  logic                      have, found, goal_hit;
  logic [ppf_pkg::DIST_W-1:0] best;
  logic [ppf_pkg::IDX_W-1:0] closest;

  logic signed [ppf_pkg::CX_W-1:0]  cx, cy, sx, sy, xs, ys;
  logic signed [ppf_pkg::ANG_W-1:0] cz;
  logic                             czero;

  logic signed [ppf_pkg::ANG_W-1:0] ferr, gerr;
  logic [ppf_pkg::ANG_W-1:0]        fmag;
  logic [ppf_pkg::VAL_W-1:0]        val;
  logic                             neg;
  logic [ppf_pkg::VAL_W+ppf_pkg::RECIP_W-1:0] prod;
  logic [ppf_pkg::MAG_W-1:0]        qmag, cmag;
  logic signed [ppf_pkg::RATE_W-1:0] frate, grate;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      path_mem[cmd.addr] <= {in_y, in_x};
    end
    if (cmd.mem_rd) begin
      rd_data <= path_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest_heading <= '0;
      end_heading    <= '0;
    end else begin
      if (cmd.pose_load) begin
        latest_heading <= ppf_pkg::ANG_W'(in_heading);
      end
      if (cmd.copy_end) begin
        end_heading <= latest_heading;
      end
    end
    if (cmd.pose_load) begin
      px <= in_x;
      py <= in_y;
    end
  end

  // Distance pipeline: memory read, squares, then add and compare.
  assign dx    = ppf_pkg::DIFF_W'(signed'(rd_data[ppf_pkg::POS_W-1:0])) - ppf_pkg::DIFF_W'(px);
  assign dy    = ppf_pkg::DIFF_W'(signed'(rd_data[2*ppf_pkg::POS_W-1:ppf_pkg::POS_W]))
                 - ppf_pkg::DIFF_W'(py);
  assign sqx_c = dx * dx;
  assign sqy_c = dy * dy;
  assign dsq   = sqx + sqy;

  always_ff @(posedge clk) begin
    tol_sq <= goal_tolerance * goal_tolerance;
    la_sq  <= look_ahead * look_ahead;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mem_rd;
      v2 <= v1;
    end
    m1  <= cmd.scan_mode;
    i1  <= cmd.addr;
    m2  <= m1;
    i2  <= i1;
    sqx <= unsigned'(sqx_c);
    sqy <= unsigned'(sqy_c);
    dx2 <= dx;
    dy2 <= dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan_clear) begin
      have  <= 1'b0;
      found <= 1'b0;
    end else if (v2) begin
      case (m2)
        ppf_pkg::SCAN_GOAL: begin
          goal_hit <= dsq < ppf_pkg::DIST_W'(tol_sq);
          tdx      <= dx2;
          tdy      <= dy2;
        end
        ppf_pkg::SCAN_MIN: begin
          if (!have || dsq < best) begin
            have    <= 1'b1;
            best    <= dsq;
            closest <= i2;
          end
        end
        ppf_pkg::SCAN_LA: begin
          if (!found && dsq >= ppf_pkg::DIST_W'(la_sq)) begin
            found <= 1'b1;
            tdx   <= dx2;
            tdy   <= dy2;
          end
        end
        default: ;
      endcase
    end
  end

  // Vectoring CORDIC, one micro-rotation per cycle.
  assign sx = ppf_pkg::CX_W'(tdx) <<< ppf_pkg::CORDIC_SHIFT;
  assign sy = ppf_pkg::CX_W'(tdy) <<< ppf_pkg::CORDIC_SHIFT;
  assign xs = cx >>> cmd.step;
  assign ys = cy >>> cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.cordic_start) begin
      czero <= (tdx == '0) && (tdy == '0);
      if (tdx < 0) begin
        cz <= (tdy >= 0) ? ppf_pkg::ANG_PI : -ppf_pkg::ANG_PI;
        cx <= -sx;
        cy <= -sy;
      end else begin
        cz <= '0;
        cx <= sx;
        cy <= sy;
      end
      if ((tdx == '0) && (tdy == '0)) begin
        cz <= '0;
      end
    end else if (cmd.cordic_step && !czero) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + ppf_pkg::atan_step(cmd.step);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - ppf_pkg::atan_step(cmd.step);
      end
    end
  end

  assign ferr = ppf_pkg::wrap_angle(cz - latest_heading);
  assign fmag = (ferr < 0) ? unsigned'(-ferr) : unsigned'(ferr);

  always_ff @(posedge clk) begin
    if (cmd.rate_calc) begin
      neg <= ferr < 0;
      val <= ppf_pkg::VAL_W'(fmag) * ppf_pkg::VAL_W'(6) + ppf_pkg::VAL_W'(2);
    end
  end

  assign prod  = val * ppf_pkg::RECIP_5;
  assign qmag  = ppf_pkg::MAG_W'(prod >> ppf_pkg::RECIP_SHIFT);
  assign cmag  = (qmag > ppf_pkg::MAX_RATE) ? ppf_pkg::MAX_RATE : qmag;
  assign frate = neg ? -signed'(ppf_pkg::RATE_W'(cmag)) : signed'(ppf_pkg::RATE_W'(cmag));

  assign gerr  = ppf_pkg::wrap_angle(end_heading + ppf_pkg::ANG_PI - latest_heading);
  assign grate = (gerr > ppf_pkg::ROT_TOL)  ? ppf_pkg::ROT_RATE :
                 (gerr < -ppf_pkg::ROT_TOL) ? -ppf_pkg::ROT_RATE : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        ppf_pkg::OUT_GOAL: begin
          linear_speed   <= '0;
          angular_rate   <= grate;
          reverse_signal <= cmd.out_rev;
          rotating       <= 1'b1;
        end
        ppf_pkg::OUT_FOLLOW: begin
          linear_speed   <= cruise_speed;
          angular_rate   <= frate;
          reverse_signal <= 1'b0;
          rotating       <= 1'b0;
        end
        default: begin
          linear_speed   <= '0;
          angular_rate   <= '0;
          reverse_signal <= 1'b0;
          rotating       <= 1'b0;
        end
      endcase
    end
  end

  assign stat.goal_hit = goal_hit;
  assign stat.closest  = closest;
  assign stat.out_busy = out_valid && !out_ready;

endmodule

FILE: hdl/ppf_ctrl.sv
module ppf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic                        in_last,
  input  logic [ppf_pkg::TICK_W-1:0]  startup_ticks,
  output ppf_pkg::ppf_cmd_t           cmd,
  input  ppf_pkg::ppf_stat_t          stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GOAL,
    S_GWAIT,
    S_SCAN1,
    S_MWAIT,
    S_SCAN2,
    S_LWAIT,
    S_CSTART,
    S_CSTEP,
    S_RATE,
    S_OUT
  } state_t;

  state_t                      state;
  logic [ppf_pkg::CNT_W-1:0]   path_count;
  logic                        path_closed;
  logic [ppf_pkg::TICK_W-1:0]  startup_count;
  logic                        goal_flag;
  logic [ppf_pkg::IDX_W-1:0]   idx;
  logic [ppf_pkg::WAIT_W-1:0]  wait_cnt;
  logic [ppf_pkg::STEP_W-1:0]  step;
  ppf_pkg::out_kind_t          out_kind;
  logic                        out_rev;

  logic                        accept;
  logic [ppf_pkg::IDX_W-1:0]   last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = ppf_pkg::IDX_W'(path_count - 1'b1);

  always_comb begin
    cmd           = '0;
    cmd.addr      = idx;
    cmd.scan_mode = ppf_pkg::SCAN_GOAL;
    cmd.step      = step;
    cmd.out_kind  = out_kind;
    cmd.out_rev   = out_rev;
    unique case (state)
      S_IDLE: begin
        if (accept && !in_mode) begin
          cmd.mem_we   = path_closed || (path_count < ppf_pkg::CNT_W'(ppf_pkg::PATH_DEPTH));
          cmd.addr     = path_closed ? '0 : ppf_pkg::IDX_W'(path_count);
          cmd.copy_end = path_closed;
        end
        cmd.pose_load = accept && in_mode;
      end
      S_GOAL: begin
        cmd.mem_rd = 1'b1;
        cmd.addr   = last;
      end
      S_GWAIT, S_MWAIT: cmd.scan_clear = (wait_cnt == '0);
      S_SCAN1: begin
        cmd.mem_rd    = 1'b1;
        cmd.scan_mode = ppf_pkg::SCAN_MIN;
      end
      S_SCAN2: begin
        cmd.mem_rd    = 1'b1;
        cmd.scan_mode = ppf_pkg::SCAN_LA;
      end
      S_LWAIT:  ;
      S_CSTART: cmd.cordic_start = 1'b1;
      S_CSTEP:  cmd.cordic_step = 1'b1;
      S_RATE:   cmd.rate_calc = 1'b1;
      S_OUT:    cmd.out_load = !stat.out_busy;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      path_count    <= '0;
      path_closed   <= 1'b1;
      startup_count <= '0;
      goal_flag     <= 1'b0;
      idx           <= '0;
      wait_cnt      <= '0;
      step          <= '0;
      out_kind      <= ppf_pkg::OUT_ZERO;
      out_rev       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && !in_mode) begin
            if (path_closed) begin
              path_count <= ppf_pkg::CNT_W'(1);
            end else if (path_count < ppf_pkg::CNT_W'(ppf_pkg::PATH_DEPTH)) begin
              path_count <= path_count + 1'b1;
            end
            path_closed <= in_last;
          end else if (accept) begin
            priority if (startup_count < startup_ticks) begin
              startup_count <= startup_count + 1'b1;
            end else if (path_count == '0) begin
              out_kind <= ppf_pkg::OUT_ZERO;
              out_rev  <= 1'b0;
              state    <= S_OUT;
            end else begin
              state <= S_GOAL;
            end
          end
        end
        S_GOAL: begin
          wait_cnt <= ppf_pkg::WAIT_W'(ppf_pkg::PIPE_LAT - 1);
          state    <= S_GWAIT;
        end
        S_GWAIT: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - 1'b1;
          end else if (stat.goal_hit) begin
            out_rev   <= !goal_flag;
            goal_flag <= 1'b1;
            out_kind  <= ppf_pkg::OUT_GOAL;
            state     <= S_OUT;
          end else begin
            goal_flag <= 1'b0;
            idx       <= '0;
            state     <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (idx == last) begin
            wait_cnt <= ppf_pkg::WAIT_W'(ppf_pkg::PIPE_LAT - 1);
            state    <= S_MWAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MWAIT: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - 1'b1;
          end else begin
            idx   <= stat.closest;
            state <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          if (idx == last) begin
            wait_cnt <= ppf_pkg::WAIT_W'(ppf_pkg::PIPE_LAT - 1);
            state    <= S_LWAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_LWAIT: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - 1'b1;
          end else begin
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          step  <= '0;
          state <= S_CSTEP;
        end
        S_CSTEP: begin
          if (step == ppf_pkg::STEP_W'(ppf_pkg::CORDIC_STEPS - 1)) begin
            state <= S_RATE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_RATE: begin
          out_kind <= ppf_pkg::OUT_FOLLOW;
          out_rev  <= 1'b0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
